[sv/tbs_pkg.sv]
// Package for the Tanimoto bit-vector similarity block.
// Holds the item structs, register indexes, widths and the popcount helper.
// No dependencies.
`timescale 1ns / 1ps

package tbs_pkg;

  localparam int MAX_WORDS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int WORD_W        = 64;
  localparam int CHUNK_W       = 16;
  localparam int CHUNKS        = WORD_W / CHUNK_W;
  localparam int CHUNK_CNT_W   = $clog2(CHUNKS);
  localparam int SUM_W         = 12;
  localparam int SIM_W         = FRACTION_BITS + 1;
  localparam int STEP_CNT_W    = $clog2(FRACTION_BITS + 1);
  localparam int WC_W          = 6;
  localparam int WPOS_W        = 5;
  localparam int CNT_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int PC_W          = $clog2(CHUNK_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] probe_word;
    logic [WORD_W-1:0] target_word;
  } in_item_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [CNT_W-1:0] row_index;
    logic [CNT_W-1:0] column_index;
    logic             matrix_done;
  } out_item_t;

  // Commands from the sequencer to the popcount accumulator.
  typedef struct packed {
    logic load;
    logic clear;
  } pop_cmd_t;

  // Running popcounts of one pair.
  typedef struct packed {
    logic [SUM_W-1:0] probe_sum;
    logic [SUM_W-1:0] target_sum;
    logic [SUM_W-1:0] intersect_sum;
  } pop_sums_t;

  // Popcount of one chunk as a small tree: nibble counts, then their sum.
  function automatic logic [PC_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] x);
    logic [2:0]      nib [CHUNK_W/4];
    logic [PC_W-1:0] total;
    total = '0;
    for (int n = 0; n < CHUNK_W / 4; n++) begin
      nib[n] = {2'b0, x[4*n]} + {2'b0, x[4*n+1]} + {2'b0, x[4*n+2]} + {2'b0, x[4*n+3]};
    end
    for (int n = 0; n < CHUNK_W / 4; n++) begin
      total = total + PC_W'(nib[n]);
    end
    return total;
  endfunction

endpackage

[sv/tanimoto_bitvector_similarity.sv]
// Top level of the Tanimoto bit-vector similarity block: sequencer, matrix
// counters, configuration registers and output register.
// Depends on tbs_pkg, tbs_pop_acc and tbs_divider.
//
// Usage: each input item carries one 64-bit probe word and the matching
// target word. After word_count items the block emits one result item with
// the ratio inter/(probe+target-inter) in unsigned Q1.16 (truncated, zero
// for an empty union) and the probe and target indices, which walk the
// probe_count by target_count matrix row by row; matrix_done marks the
// last pair. Both channels use valid and stall.
// Each item is accepted in the idle state, counted by the shared 16-bit
// popcount slice in four chunks and closed in the FIN state. The last word
// of a pair then starts the one-bit-per-cycle divider; the sequencer sees it
// finish and loads the output register when that register is free, and only
// then takes the next word.
// The block stalls its input while an item is at work.
// A finished result waits in the output register while the receiver stalls;
// the next pair's words are taken meanwhile, and only the next result waits.
// Reset clears all counters and sums and loads word_count 32, probe_count 1
// and target_count 1. Configuration writes take effect at once and never
// clear running state; an index past the register list is ignored.
`timescale 1ns / 1ps

module tanimoto_bitvector_similarity (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tbs_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tbs_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tbs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [WC_W-1:0]   word_count_q;
  logic [CNT_W-1:0]  probe_count_q;
  logic [CNT_W-1:0]  target_count_q;
  logic [WPOS_W-1:0] word_pos_q, word_pos_d;
  logic [CNT_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              in_accept;
  logic              out_free;
  pop_cmd_t          pop_cmd;
  logic              pop_done;
  pop_sums_t         sums;
  logic              div_start;
  logic              div_done;
  logic [SIM_W-1:0]  quot;
  logic [SUM_W:0]    union_wide;
  logic [WC_W-1:0]   words_eff;
  logic [CNT_W-1:0]  rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic              last_word;
  logic              last_col;
  logic              last_row;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Zero counts act as one; word counts past the maximum saturate.
  always_comb begin
    if (word_count_q == '0) begin
      words_eff = WC_W'(1);
    end else if (word_count_q > WC_W'(MAX_WORDS)) begin
      words_eff = WC_W'(MAX_WORDS);
    end else begin
      words_eff = word_count_q;
    end
  end
  assign rows_eff = (probe_count_q == '0) ? CNT_W'(1) : probe_count_q;
  assign cols_eff = (target_count_q == '0) ? CNT_W'(1) : target_count_q;

  assign last_word = ({1'b0, word_pos_q} + WC_W'(1)) >= words_eff;
  assign last_col  = ({1'b0, col_q} + 17'd1) >= {1'b0, cols_eff};
  assign last_row  = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff};

  assign union_wide = {1'b0, sums.probe_sum} + {1'b0, sums.target_sum}
                    - {1'b0, sums.intersect_sum};

  always_comb begin
    state_d     = state_q;
    word_pos_d  = word_pos_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_cmd     = '0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          pop_cmd.load = 1'b1;
          state_d      = ST_POP;
        end
      end
      ST_POP: begin
        if (pop_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (last_word) begin
          div_start     = 1'b1;
          pop_cmd.clear = 1'b1;
          word_pos_d    = '0;
          state_d       = ST_DIV;
        end else begin
          word_pos_d = word_pos_q + WPOS_W'(1);
          state_d    = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.similarity   = quot;
          out_d.row_index    = row_q;
          out_d.column_index = col_q;
          out_d.matrix_done  = last_col && last_row;
          out_valid_d        = 1'b1;
          if (last_col) begin
            col_d = '0;
            row_d = last_row ? '0 : row_q + CNT_W'(1);
          end else begin
            col_d = col_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      word_pos_q     <= '0;
      row_q          <= '0;
      col_q          <= '0;
      out_valid_q    <= 1'b0;
      word_count_q   <= WC_W'(MAX_WORDS);
      probe_count_q  <= CNT_W'(1);
      target_count_q <= CNT_W'(1);
    end else begin
      state_q     <= state_d;
      word_pos_q  <= word_pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WORD_COUNT:   word_count_q   <= cfg_data_i[WC_W-1:0];
          CFG_PROBE_COUNT:  probe_count_q  <= cfg_data_i;
          CFG_TARGET_COUNT: target_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  tbs_pop_acc u_pop_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pop_cmd),
    .item_i (in_data_i),
    .done_o (pop_done),
    .sums_o (sums)
  );

  tbs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .inter_i (sums.intersect_sum),
    .union_i (union_wide[SUM_W-1:0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/tbs_pop_acc.sv]
// Popcount accumulator: counts one word pair a 16-bit chunk per cycle
// with one shared popcount slice. Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_pop_acc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tbs_pkg::pop_cmd_t         cmd_i,
  input  tbs_pkg::in_item_t         item_i,
  output logic                      done_o,
  output tbs_pkg::pop_sums_t        sums_o
);
  import tbs_pkg::*;

  logic [WORD_W-1:0]      probe_q, probe_d;
  logic [WORD_W-1:0]      target_q, target_d;
  logic [CHUNK_CNT_W-1:0] chunk_q, chunk_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  pop_sums_t              sums_q, sums_d;
  logic [PC_W-1:0]        pc_probe, pc_target, pc_both;

  assign pc_probe  = popcount_chunk(probe_q[CHUNK_W-1:0]);
  assign pc_target = popcount_chunk(target_q[CHUNK_W-1:0]);
  assign pc_both   = popcount_chunk(probe_q[CHUNK_W-1:0] & target_q[CHUNK_W-1:0]);

  always_comb begin
    probe_d  = probe_q;
    target_d = target_q;
    chunk_d  = chunk_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    sums_d   = sums_q;
    if (cmd_i.clear) begin
      sums_d = '0;
    end
    if (cmd_i.load) begin
      probe_d  = item_i.probe_word;
      target_d = item_i.target_word;
      chunk_d  = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      sums_d.probe_sum     = sums_q.probe_sum + SUM_W'(pc_probe);
      sums_d.target_sum    = sums_q.target_sum + SUM_W'(pc_target);
      sums_d.intersect_sum = sums_q.intersect_sum + SUM_W'(pc_both);
      probe_d  = probe_q >> CHUNK_W;
      target_d = target_q >> CHUNK_W;
      chunk_d  = chunk_q + CHUNK_CNT_W'(1);
      if (chunk_q == CHUNK_CNT_W'(CHUNKS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      sums_q  <= '0;
    end else begin
      chunk_q <= chunk_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      sums_q  <= sums_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q  <= probe_d;
    target_q <= target_d;
  end

  assign done_o = done_q;
  assign sums_o = sums_q;

endmodule

[sv/tbs_divider.sv]
// Restoring divider for the similarity ratio: one quotient bit per cycle
// through a single compare-and-subtract. Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tbs_pkg::SUM_W-1:0]    inter_i,
  input  logic [tbs_pkg::SUM_W-1:0]    union_i,
  output logic                         done_o,
  output logic [tbs_pkg::SIM_W-1:0]    quot_o
);
  import tbs_pkg::*;

  logic [SUM_W-1:0]      rem_q, rem_d;
  logic [SUM_W-1:0]      div_q, div_d;
  logic [SIM_W-1:0]      quot_q, quot_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  zero_q, zero_d;
  logic [SUM_W:0]        trial;
  logic [SUM_W:0]        divisor;
  logic [SUM_W:0]        diff;
  logic                  fits;

  // The start cycle yields the integer bit; each busy cycle one fraction bit.
  assign trial   = start_i ? {1'b0, inter_i} : {rem_q, 1'b0};
  assign divisor = start_i ? {1'b0, union_i} : {1'b0, div_q};
  assign diff    = trial - divisor;
  assign fits    = trial >= divisor;

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    if (start_i) begin
      div_d  = union_i;
      zero_d = (union_i == '0);
      rem_d  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quot_d = {{(SIM_W-1){1'b0}}, fits};
      cnt_d  = STEP_CNT_W'(FRACTION_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quot_d = {quot_q[SIM_W-2:0], fits};
      cnt_d  = cnt_q - STEP_CNT_W'(1);
      if (cnt_q == STEP_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
    zero_q <= zero_d;
  end

  // An empty union gives a ratio of zero.
  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule
